FILE: rtl/core/four_register_alu_execute_macros.svh
// ----------------------------------------------------------------------------
// four register alu execute assertion macros
// shared concurrent assertion forms for the execute block checkers
// ----------------------------------------------------------------------------
`ifndef FOUR_REGISTER_ALU_EXECUTE_MACROS_SVH
`define FOUR_REGISTER_ALU_EXECUTE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FRAX_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frax: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define FRAX_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frax: next-cycle check failed");

`endif

FILE: rtl/core/frax_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frax_pkg
// shared types and constants of the four register alu execute block
// ----------------------------------------------------------------------------
package frax_pkg;

    // width of every external operand and result field
    localparam int FIELD_W     = 32;
    // widest supported datapath, also the padded multiplier operand width
    localparam int WIDE_W      = 64;
    // multiplier operand slice width
    localparam int MUL_HALF    = 32;
    // depth of the decoded queue and of the result queue
    localparam int QUEUE_DEPTH = 2;

    // operation class after decode
    typedef enum logic [2:0] {
        OP_GT,
        OP_EQ,
        OP_AND,
        OP_OR,
        OP_SET,
        OP_ADD,
        OP_MUL
    } t_op;

    // decoded control word handed from front to back
    typedef struct packed {
        logic bad;
        t_op  op;
        logic a_reg;
        logic b_reg;
    } t_ctl;

endpackage

FILE: rtl/core/frax_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frax_fifo
// small register based queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module frax_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wp;
    logic [PTR_W-1:0] n_rp;
    logic [CNT_W-1:0] n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push_ok) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop_ok) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

FILE: rtl/core/frax_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frax_front
// accepts instructions, decodes the opcode and checks register operands
// ----------------------------------------------------------------------------
module frax_front
    import frax_pkg::*;
#(
    parameter int NUM_REGS   = 4,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = $clog2(NUM_REGS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    output logic                         o_full,
    input  logic [3:0]                   i_func,
    input  logic signed [FIELD_W-1:0]    i_opa,
    input  logic signed [FIELD_W-1:0]    i_opb,
    input  logic signed [FIELD_W-1:0]    i_dest,
    output logic                         o_vld,
    input  logic                         i_q_full,
    output t_ctl                         o_ctl,
    output logic [IDX_W-1:0]             o_a_idx,
    output logic [IDX_W-1:0]             o_b_idx,
    output logic [IDX_W-1:0]             o_d_idx,
    output logic [DATA_WIDTH-1:0]        o_a_imm,
    output logic [DATA_WIDTH-1:0]        o_b_imm
);

    typedef enum logic [3:0] {
        F_GTRI = 4'd0,
        F_BANI = 4'd1,
        F_EQRR = 4'd2,
        F_GTIR = 4'd3,
        F_EQIR = 4'd4,
        F_BORI = 4'd5,
        F_SETI = 4'd6,
        F_SETR = 4'd7,
        F_ADDR = 4'd8,
        F_BORR = 4'd9,
        F_MULI = 4'd10,
        F_BANR = 4'd11,
        F_ADDI = 4'd12,
        F_EQRI = 4'd13,
        F_MULR = 4'd14,
        F_GTRR = 4'd15
    } t_func;

    logic                  r_vld;
    t_ctl                  r_ctl;
    logic [IDX_W-1:0]      r_a_idx;
    logic [IDX_W-1:0]      r_b_idx;
    logic [IDX_W-1:0]      r_d_idx;
    logic [DATA_WIDTH-1:0] r_a_imm;
    logic [DATA_WIDTH-1:0] r_b_imm;

    t_ctl                  n_ctl;
    logic [WIDE_W-1:0]     a_ext;
    logic [WIDE_W-1:0]     b_ext;
    logic                  a_ok;
    logic                  b_ok;
    logic                  d_ok;
    logic                  accept;

    assign o_full = r_vld && i_q_full;
    assign accept = i_vld && !o_full;

    // register index check on the raw 32-bit value, negatives are huge
    assign a_ok = ($unsigned(i_opa) < FIELD_W'(NUM_REGS));
    assign b_ok = ($unsigned(i_opb) < FIELD_W'(NUM_REGS));
    assign d_ok = ($unsigned(i_dest) < FIELD_W'(NUM_REGS));

    // immediates sign extend from the field, then wrap to the datapath
    assign a_ext = {{(WIDE_W - FIELD_W){i_opa[FIELD_W-1]}}, i_opa};
    assign b_ext = {{(WIDE_W - FIELD_W){i_opb[FIELD_W-1]}}, i_opb};

    always_comb begin
        n_ctl       = '0;
        n_ctl.op    = OP_SET;
        case (t_func'(i_func))
            F_GTRI: begin n_ctl.op = OP_GT;  n_ctl.a_reg = 1'b1; end
            F_BANI: begin n_ctl.op = OP_AND; n_ctl.a_reg = 1'b1; end
            F_EQRR: begin n_ctl.op = OP_EQ;  n_ctl.a_reg = 1'b1; n_ctl.b_reg = 1'b1; end
            F_GTIR: begin n_ctl.op = OP_GT;  n_ctl.b_reg = 1'b1; end
            F_EQIR: begin n_ctl.op = OP_EQ;  n_ctl.b_reg = 1'b1; end
            F_BORI: begin n_ctl.op = OP_OR;  n_ctl.a_reg = 1'b1; end
            F_SETI: begin n_ctl.op = OP_SET; end
            F_SETR: begin n_ctl.op = OP_SET; n_ctl.a_reg = 1'b1; end
            F_ADDR: begin n_ctl.op = OP_ADD; n_ctl.a_reg = 1'b1; n_ctl.b_reg = 1'b1; end
            F_BORR: begin n_ctl.op = OP_OR;  n_ctl.a_reg = 1'b1; n_ctl.b_reg = 1'b1; end
            F_MULI: begin n_ctl.op = OP_MUL; n_ctl.a_reg = 1'b1; end
            F_BANR: begin n_ctl.op = OP_AND; n_ctl.a_reg = 1'b1; n_ctl.b_reg = 1'b1; end
            F_ADDI: begin n_ctl.op = OP_ADD; n_ctl.a_reg = 1'b1; end
            F_EQRI: begin n_ctl.op = OP_EQ;  n_ctl.a_reg = 1'b1; end
            F_MULR: begin n_ctl.op = OP_MUL; n_ctl.a_reg = 1'b1; n_ctl.b_reg = 1'b1; end
            F_GTRR: begin n_ctl.op = OP_GT;  n_ctl.a_reg = 1'b1; n_ctl.b_reg = 1'b1; end
            default: begin n_ctl.op = OP_SET; end
        endcase
        n_ctl.bad = !d_ok || (n_ctl.a_reg && !a_ok) || (n_ctl.b_reg && !b_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (!i_q_full) begin
            r_vld <= 1'b0;
        end
        if (accept) begin
            r_ctl   <= n_ctl;
            // unchecked or bad indices are parked at zero
            r_a_idx <= (n_ctl.a_reg && !n_ctl.bad) ? i_opa[IDX_W-1:0] : '0;
            r_b_idx <= (n_ctl.b_reg && !n_ctl.bad) ? i_opb[IDX_W-1:0] : '0;
            r_d_idx <= n_ctl.bad ? '0 : i_dest[IDX_W-1:0];
            r_a_imm <= a_ext[DATA_WIDTH-1:0];
            r_b_imm <= b_ext[DATA_WIDTH-1:0];
        end
    end

    assign o_vld   = r_vld;
    assign o_ctl   = r_ctl;
    assign o_a_idx = r_a_idx;
    assign o_b_idx = r_b_idx;
    assign o_d_idx = r_d_idx;
    assign o_a_imm = r_a_imm;
    assign o_b_imm = r_b_imm;

endmodule

FILE: rtl/core/frax_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frax_back
// register file read, alu, sliced multiply with a partial-product register and write-back
// ----------------------------------------------------------------------------
module frax_back
    import frax_pkg::*;
#(
    parameter int NUM_REGS   = 4,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = $clog2(NUM_REGS)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    input  t_ctl                  i_ctl,
    input  logic [IDX_W-1:0]      i_a_idx,
    input  logic [IDX_W-1:0]      i_b_idx,
    input  logic [IDX_W-1:0]      i_d_idx,
    input  logic [DATA_WIDTH-1:0] i_a_imm,
    input  logic [DATA_WIDTH-1:0] i_b_imm,
    input  logic                  i_out_full,
    output logic                  o_out_push,
    output logic                  o_bad,
    output logic [DATA_WIDTH-1:0] o_wval,
    output logic [DATA_WIDTH-1:0] o_reg0
);

    logic [DATA_WIDTH-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   r_wr_vld;
    logic [DATA_WIDTH-1:0] r_reg0;

    logic                  r_e_vld;
    t_ctl                  r_e_ctl;
    logic [IDX_W-1:0]      r_e_d_idx;
    logic [DATA_WIDTH-1:0] r_a_mem;
    logic [DATA_WIDTH-1:0] r_b_mem;
    logic [DATA_WIDTH-1:0] r_a_ovr;
    logic [DATA_WIDTH-1:0] r_b_ovr;
    logic                  r_a_use;
    logic                  r_b_use;

    logic                  r_m_vld;
    logic [WIDE_W-1:0]     r_p_ll;
    logic [MUL_HALF-1:0]   r_p_lh;
    logic [MUL_HALF-1:0]   r_p_hl;

    logic [DATA_WIDTH-1:0] e_a;
    logic [DATA_WIDTH-1:0] e_b;
    logic [WIDE_W-1:0]     a_wide;
    logic [WIDE_W-1:0]     b_wide;
    logic [WIDE_W-1:0]     prod;
    logic [DATA_WIDTH-1:0] e_val;
    logic                  is_mul;
    logic                  e_done;
    logic                  e_load;
    logic                  e_wr;
    logic                  n_a_use;
    logic                  n_b_use;
    logic [DATA_WIDTH-1:0] n_a_ovr;
    logic [DATA_WIDTH-1:0] n_b_ovr;

    assign e_a    = r_a_use ? r_a_ovr : r_a_mem;
    assign e_b    = r_b_use ? r_b_ovr : r_b_mem;
    assign is_mul = (r_e_ctl.op == OP_MUL) && !r_e_ctl.bad;
    assign e_done = r_e_vld && !i_out_full && (!is_mul || r_m_vld);
    assign e_load = !i_q_empty && (!r_e_vld || e_done);
    assign e_wr   = e_done && !r_e_ctl.bad;

    // multiply in 32-bit slices, only the low datapath bits are kept
    assign a_wide = WIDE_W'(e_a);
    assign b_wide = WIDE_W'(e_b);
    assign prod   = r_p_ll + {r_p_lh + r_p_hl, MUL_HALF'(0)};

    always_comb begin
        case (r_e_ctl.op)
            OP_GT:   e_val = DATA_WIDTH'($signed(e_a) > $signed(e_b));
            OP_EQ:   e_val = DATA_WIDTH'(e_a == e_b);
            OP_AND:  e_val = e_a & e_b;
            OP_OR:   e_val = e_a | e_b;
            OP_SET:  e_val = e_a;
            OP_ADD:  e_val = e_a + e_b;
            OP_MUL:  e_val = prod[DATA_WIDTH-1:0];
            default: e_val = '0;
        endcase
    end

    // operand source on load: immediate, forwarded write, reset value or memory
    always_comb begin
        if (!i_ctl.a_reg) begin
            n_a_use = 1'b1;
            n_a_ovr = i_a_imm;
        end else if (e_wr && (r_e_d_idx == i_a_idx)) begin
            n_a_use = 1'b1;
            n_a_ovr = e_val;
        end else if (!r_wr_vld[i_a_idx]) begin
            n_a_use = 1'b1;
            n_a_ovr = '0;
        end else begin
            n_a_use = 1'b0;
            n_a_ovr = '0;
        end
        if (!i_ctl.b_reg) begin
            n_b_use = 1'b1;
            n_b_ovr = i_b_imm;
        end else if (e_wr && (r_e_d_idx == i_b_idx)) begin
            n_b_use = 1'b1;
            n_b_ovr = e_val;
        end else if (!r_wr_vld[i_b_idx]) begin
            n_b_use = 1'b1;
            n_b_ovr = '0;
        end else begin
            n_b_use = 1'b0;
            n_b_ovr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld  <= 1'b0;
            r_m_vld  <= 1'b0;
            r_wr_vld <= '0;
            r_reg0   <= '0;
        end else begin
            if (e_load) begin
                r_e_vld <= 1'b1;
            end else if (e_done) begin
                r_e_vld <= 1'b0;
            end
            if (e_done) begin
                r_m_vld <= 1'b0;
            end else if (r_e_vld && is_mul) begin
                r_m_vld <= 1'b1;
            end
            if (e_wr) begin
                r_wr_vld[r_e_d_idx] <= 1'b1;
                if (r_e_d_idx == IDX_W'(0)) begin
                    r_reg0 <= e_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_load) begin
            r_e_ctl   <= i_ctl;
            r_e_d_idx <= i_d_idx;
            r_a_use   <= n_a_use;
            r_b_use   <= n_b_use;
            r_a_ovr   <= n_a_ovr;
            r_b_ovr   <= n_b_ovr;
        end
        if (r_e_vld && is_mul && !r_m_vld) begin
            r_p_ll <= WIDE_W'(a_wide[MUL_HALF-1:0]) * WIDE_W'(b_wide[MUL_HALF-1:0]);
            r_p_lh <= a_wide[MUL_HALF-1:0] * b_wide[WIDE_W-1:MUL_HALF];
            r_p_hl <= a_wide[WIDE_W-1:MUL_HALF] * b_wide[MUL_HALF-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_wr) begin
            r_mem[r_e_d_idx] <= e_val;
        end
        if (e_load) begin
            r_a_mem <= r_mem[i_a_idx];
            r_b_mem <= r_mem[i_b_idx];
        end
    end

    assign o_q_pop    = e_load;
    assign o_out_push = e_done;
    assign o_bad      = r_e_ctl.bad;
    assign o_wval     = r_e_ctl.bad ? '0 : e_val;
    assign o_reg0     = (e_wr && (r_e_d_idx == IDX_W'(0))) ? e_val : r_reg0;

endmodule

FILE: rtl/core/four_register_alu_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_register_alu_execute
// sixteen opcode instruction executor on a small signed register file
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// -------   ---------  -----------------  ----------------------------------
// input     in         push / full        i_func, i_opa, i_opb, i_dest
// result    out        pop / empty        o_bad_register, o_written_value,
//                                         o_reg_zero
//
// one instruction per cycle sustained, unless a multiply or full result queue
// holds execute; a multiply waits for the sliced multiplier's partial register
// a result passes the front register, decoded queue, execute and result queue
// reset is synchronous, active low, and makes every register read as zero until written
// a full result queue stalls execute, which backs up the decoded queue
// and then raises full
//
module four_register_alu_execute
    import frax_pkg::*;
#(
    parameter int NUM_REGS   = 4,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input transaction
    input  logic                      push,
    output logic                      full,
    input  logic [3:0]                i_func,
    input  logic signed [FIELD_W-1:0] i_opa,
    input  logic signed [FIELD_W-1:0] i_opb,
    input  logic signed [FIELD_W-1:0] i_dest,
    // result transaction
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_bad_register,
    output logic signed [FIELD_W-1:0] o_written_value,
    output logic signed [FIELD_W-1:0] o_reg_zero
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int CTL_W = $bits(t_ctl);
    localparam int Q_W   = CTL_W + 3 * IDX_W + 2 * DATA_WIDTH;
    localparam int OUT_W = 1 + 2 * FIELD_W;

    // front to decoded queue
    logic                  f_vld;
    t_ctl                  f_ctl;
    logic [IDX_W-1:0]      f_a_idx;
    logic [IDX_W-1:0]      f_b_idx;
    logic [IDX_W-1:0]      f_d_idx;
    logic [DATA_WIDTH-1:0] f_a_imm;
    logic [DATA_WIDTH-1:0] f_b_imm;

    // decoded queue
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic [Q_W-1:0]        q_wdata;
    logic [Q_W-1:0]        q_rdata;

    // decoded queue to back
    t_ctl                  q_ctl;
    logic [IDX_W-1:0]      q_a_idx;
    logic [IDX_W-1:0]      q_b_idx;
    logic [IDX_W-1:0]      q_d_idx;
    logic [DATA_WIDTH-1:0] q_a_imm;
    logic [DATA_WIDTH-1:0] q_b_imm;

    // back to result queue
    logic                  b_push;
    logic                  b_bad;
    logic [DATA_WIDTH-1:0] b_wval;
    logic [DATA_WIDTH-1:0] b_reg0;
    logic [WIDE_W-1:0]     b_wval_ext;
    logic [WIDE_W-1:0]     b_reg0_ext;
    logic                  r_full;
    logic [OUT_W-1:0]      r_wdata;
    logic [OUT_W-1:0]      r_rdata;

    // front: take the instruction, decode and check register operands
    frax_front #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (push),
        .o_full   (full),
        .i_func   (i_func),
        .i_opa    (i_opa),
        .i_opb    (i_opb),
        .i_dest   (i_dest),
        .o_vld    (f_vld),
        .i_q_full (q_full),
        .o_ctl    (f_ctl),
        .o_a_idx  (f_a_idx),
        .o_b_idx  (f_b_idx),
        .o_d_idx  (f_d_idx),
        .o_a_imm  (f_a_imm),
        .o_b_imm  (f_b_imm)
    );

    assign q_wdata = {f_ctl, f_a_idx, f_b_idx, f_d_idx, f_a_imm, f_b_imm};

    // short queue decoupling decode from execute
    frax_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_dec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_vld),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {q_ctl, q_a_idx, q_b_idx, q_d_idx, q_a_imm, q_b_imm} = q_rdata;

    // back: register read with forwarding, alu and write-back
    frax_back #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_ctl      (q_ctl),
        .i_a_idx    (q_a_idx),
        .i_b_idx    (q_b_idx),
        .i_d_idx    (q_d_idx),
        .i_a_imm    (q_a_imm),
        .i_b_imm    (q_b_imm),
        .i_out_full (r_full),
        .o_out_push (b_push),
        .o_bad      (b_bad),
        .o_wval     (b_wval),
        .o_reg0     (b_reg0)
    );

    // results leave as the low field bits of the datapath values
    assign b_wval_ext = WIDE_W'(b_wval);
    assign b_reg0_ext = WIDE_W'(b_reg0);
    assign r_wdata    = {b_bad, b_wval_ext[FIELD_W-1:0], b_reg0_ext[FIELD_W-1:0]};

    // result queue, lets execute continue while a result waits
    frax_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_wdata (r_wdata),
        .o_full  (r_full),
        .i_pop   (pop),
        .o_rdata (r_rdata),
        .o_empty (empty)
    );

    assign {o_bad_register, o_written_value, o_reg_zero} = r_rdata;

endmodule

FILE: rtl/core/frax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frax_checker
// port level checks of the four register alu execute block
// ----------------------------------------------------------------------------
`include "four_register_alu_execute_macros.svh"

module frax_checker
    import frax_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic                      o_bad_register,
    input logic signed [FIELD_W-1:0] o_written_value,
    input logic signed [FIELD_W-1:0] o_reg_zero
);

    logic                      show;
    logic                      taken;
    logic                      show_bad;
    logic signed [FIELD_W-1:0] reg0;
    logic [2*FIELD_W:0]        res_bus;

    assign show     = !empty;
    assign taken    = !empty && pop;
    assign show_bad = !empty && o_bad_register;
    assign reg0     = o_reg_zero;
    assign res_bus  = {o_bad_register, o_written_value, o_reg_zero};

    // nothing queued and room to accept right after reset
    `FRAX_ASSERT_IMPLY(a_rst_idle, i_clk, i_rst_n, $past(!i_rst_n), empty && !full)

    // a rejected instruction reports a zero written value
    `FRAX_ASSERT_IMPLY(a_bad_zero, i_clk, i_rst_n, show_bad, o_written_value == '0)

    // a rejected instruction leaves register zero as the previous result showed it
    `FRAX_ASSERT_IMPLY(a_bad_keeps_r0, i_clk, i_rst_n, taken ##1 show_bad, reg0 == $past(reg0))

    // a waiting result holds until taken
    `FRAX_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, show && !pop, show && $stable(res_bus))

endmodule

bind four_register_alu_execute frax_checker u_frax_checker (.*);

FILE: tb/frax_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frax_tb_pkg
// opcode names and register file size shared by the execute block testbench
// ----------------------------------------------------------------------------
package frax_tb_pkg;

    // registers in the file under test
    localparam int REG_COUNT = 4;

    // instruction opcodes in dispatch table order
    typedef enum logic [3:0] {
        FN_GTRI = 4'd0,
        FN_BANI = 4'd1,
        FN_EQRR = 4'd2,
        FN_GTIR = 4'd3,
        FN_EQIR = 4'd4,
        FN_BORI = 4'd5,
        FN_SETI = 4'd6,
        FN_SETR = 4'd7,
        FN_ADDR = 4'd8,
        FN_BORR = 4'd9,
        FN_MULI = 4'd10,
        FN_BANR = 4'd11,
        FN_ADDI = 4'd12,
        FN_EQRI = 4'd13,
        FN_MULR = 4'd14,
        FN_GTRR = 4'd15
    } t_opcode;

endpackage

FILE: tb/four_register_alu_execute_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_register_alu_execute_checker
// watches both queues of the execute block, runs its own register file
// alongside it and compares every popped result with the predicted one
// ----------------------------------------------------------------------------
module four_register_alu_execute_checker
    import frax_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [3:0]  i_func,
    input  logic [31:0] i_opa,
    input  logic [31:0] i_opb,
    input  logic [31:0] i_dest,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_bad_register,
    input  logic [31:0] i_written_value,
    input  logic [31:0] i_reg_zero,
    output int          o_mismatch_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic        bad;
        logic [31:0] written;
        logic [31:0] reg_zero;
    } t_exec_result;

    logic [31:0]  shadow_regs [REG_COUNT];
    t_exec_result exec_results_q [$];
    int           mismatches = 0;

    assign o_mismatch_count = mismatches;

    always @(posedge i_clk) begin
        t_exec_result got;
        t_exec_result want;
        t_exec_result calc;
        t_opcode      fn;
        logic         a_reg;
        logic         b_reg;
        logic [31:0]  a;
        logic [31:0]  b;
        if (!i_rst_n) begin
            foreach (shadow_regs[i]) shadow_regs[i] = '0;
            exec_results_q.delete();
        end else begin
            // result side first, a result can never belong to this edge's push
            if (i_pop && !i_empty) begin
                got = '{i_bad_register, i_written_value, i_reg_zero};
                if (exec_results_q.size() == 0) begin
                    $error("result transaction with no instruction outstanding");
                    mismatches++;
                end else begin
                    want = exec_results_q.pop_front();
                    if (got.bad !== want.bad) begin
                        $error("bad_register: expected %0d, actual %0d", want.bad, got.bad);
                        mismatches++;
                    end
                    if (got.written !== want.written) begin
                        $error("written_value: expected %h, actual %h",
                               want.written, got.written);
                        mismatches++;
                    end
                    if (got.reg_zero !== want.reg_zero) begin
                        $error("reg_zero: expected %h, actual %h",
                               want.reg_zero, got.reg_zero);
                        mismatches++;
                    end
                end
            end

            if (i_push && !i_full) begin
                fn = t_opcode'(i_func);
                a_reg = fn inside {FN_GTRI, FN_BANI, FN_EQRR, FN_BORI, FN_SETR, FN_ADDR,
                                   FN_BORR, FN_MULI, FN_BANR, FN_ADDI, FN_EQRI, FN_MULR,
                                   FN_GTRR};
                b_reg = fn inside {FN_EQRR, FN_GTIR, FN_EQIR, FN_ADDR, FN_BORR, FN_BANR,
                                   FN_MULR, FN_GTRR};
                // indexes are unsigned compares, so negative ones are out of range
                calc.bad = (i_dest >= REG_COUNT) || (a_reg && i_opa >= REG_COUNT)
                        || (b_reg && i_opb >= REG_COUNT);
                calc.written = '0;
                if (!calc.bad) begin
                    a = a_reg ? shadow_regs[i_opa[1:0]] : i_opa;
                    b = b_reg ? shadow_regs[i_opb[1:0]] : i_opb;
                    case (fn)
                        FN_GTRI, FN_GTIR, FN_GTRR: calc.written = {31'd0, $signed(a) > $signed(b)};
                        FN_EQRR, FN_EQIR, FN_EQRI: calc.written = {31'd0, a == b};
                        FN_BANI, FN_BANR:          calc.written = a & b;
                        FN_BORI, FN_BORR:          calc.written = a | b;
                        FN_SETI, FN_SETR:          calc.written = a;
                        FN_ADDR, FN_ADDI:          calc.written = a + b;
                        default:                   calc.written = a * b;
                    endcase
                    shadow_regs[i_dest[1:0]] = calc.written;
                end
                calc.reg_zero = shadow_regs[0];
                exec_results_q.push_back(calc);
            end
        end
        o_outstanding <= exec_results_q.size();
    end

endmodule

FILE: tb/four_register_alu_execute_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_register_alu_execute_tb
// drives instruction transactions into the execute block and pops its
// results with random gaps on both sides; a checker beside the block
// predicts every result and the top reports the verdict
// ----------------------------------------------------------------------------
module four_register_alu_execute_tb
    import frax_tb_pkg::*;
;

    localparam int RANDOM_ITEMS = 900;
    // cycles with no transaction on either side before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    // settle time after the last result
    localparam int DRAIN_CYCLES = 16;

    // register indexes used by the directed instructions
    localparam logic [31:0] R0 = 32'd0;
    localparam logic [31:0] R1 = 32'd1;
    localparam logic [31:0] R2 = 32'd2;
    localparam logic [31:0] R3 = 32'd3;
    // first index past the file
    localparam logic [31:0] R_OUT = REG_COUNT;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] ALL_ONE = 32'hffff_ffff;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic [3:0]  i_func  = '0;
    logic [31:0] i_opa   = '0;
    logic [31:0] i_opb   = '0;
    logic [31:0] i_dest  = '0;
    logic        empty;
    logic        pop     = 1'b0;
    logic        o_bad_register;
    logic [31:0] o_written_value;
    logic [31:0] o_reg_zero;

    int mismatch_count;
    int outstanding;
    int idle_cycles   = 0;
    // remaining transactions of a stretch with no idling, per side
    int send_calm     = 0;
    int pop_calm      = 0;

    four_register_alu_execute DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_func          (i_func),
        .i_opa           (i_opa),
        .i_opb           (i_opb),
        .i_dest          (i_dest),
        .empty           (empty),
        .pop             (pop),
        .o_bad_register  (o_bad_register),
        .o_written_value (o_written_value),
        .o_reg_zero      (o_reg_zero)
    );

    four_register_alu_execute_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_func           (i_func),
        .i_opa            (i_opa),
        .i_opb            (i_opb),
        .i_dest           (i_dest),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_bad_register   (o_bad_register),
        .i_written_value  (o_written_value),
        .i_reg_zero       (o_reg_zero),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // random gap before the next transaction, with occasional
    // stretches of back-to-back transactions
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // operand that is mostly a valid register index, sometimes an out of
    // range one, sometimes a full-width value; valid_pct sets the mix
    function automatic logic [31:0] draw_operand(int valid_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < valid_pct) return $urandom_range(0, REG_COUNT - 1);
        if (pick < valid_pct + 2) begin
            case ($urandom_range(0, 3))
                0:       return R_OUT;
                1:       return ALL_ONE;
                2:       return INT_MIN;
                default: return INT_MAX;
            endcase
        end
        case ($urandom_range(0, 4))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return -$urandom_range(1, 16);
            default: return $urandom();
        endcase
    endfunction

    // one input transaction, held until the block takes it
    task automatic send_instr(t_opcode fn, logic [31:0] a, logic [31:0] b, logic [31:0] d);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_func <= fn;
        i_opa  <= a;
        i_opb  <= b;
        i_dest <= d;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    // stop sending until the block has handed back every result
    task automatic wait_all_returned();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // result side: pop with its own random gaps for the whole run
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_wait(pop_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_opcode fn;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: load extremes into the file, unused operands out of range
        send_instr(FN_SETI, INT_MIN, INT_MAX, R1);
        send_instr(FN_SETI, INT_MAX, 32'h1234_5678, R2);
        send_instr(FN_SETI, ALL_ONE, ALL_ONE, R3);
        send_instr(FN_SETR, R1, -32'sd5, R0);
        // wrapping add and multiply
        send_instr(FN_ADDR, R1, R2, R0);
        send_instr(FN_ADDI, R2, 32'd1, R0);
        send_instr(FN_MULR, R2, R2, R1);
        send_instr(FN_MULI, R3, INT_MIN, R2);
        send_instr(FN_MULI, R0, INT_MAX, R3);
        // bitwise forms
        send_instr(FN_BANR, R3, R2, R0);
        send_instr(FN_BANI, R2, 32'h0f0f_0f0f, R3);
        send_instr(FN_BORR, R0, R1, R2);
        send_instr(FN_BORI, R1, ALL_ONE, R0);
        // signed compares and equality in every form
        send_instr(FN_GTRR, R2, R3, R1);
        send_instr(FN_GTRI, R3, INT_MIN, R0);
        send_instr(FN_GTIR, INT_MAX, R0, R2);
        send_instr(FN_GTIR, 32'd99, R2, R1);
        send_instr(FN_EQRR, R1, R1, R3);
        send_instr(FN_EQRI, R0, 32'd0, R1);
        send_instr(FN_EQIR, ALL_ONE, R3, R0);
        // bad register index on each checked operand, negative ones too
        send_instr(FN_ADDR, R_OUT, R0, R0);
        send_instr(FN_EQRR, R0, ALL_ONE, R0);
        send_instr(FN_SETI, 32'd5, R0, R_OUT);
        send_instr(FN_SETI, 32'd5, R0, INT_MIN);
        send_instr(FN_SETR, R3, R0, R0);

        // random instruction stream, mostly valid indexes
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) wait_all_returned();
            fn = t_opcode'($urandom_range(0, 15));
            send_instr(fn, draw_operand(90), draw_operand(90), draw_operand(96));
        end

        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/frax_pkg.sv
rtl/core/frax_fifo.sv
rtl/core/frax_front.sv
rtl/core/frax_back.sv
rtl/core/four_register_alu_execute.sv
rtl/core/frax_checker.sv
tb/frax_tb_pkg.sv
tb/four_register_alu_execute_checker.sv
tb/four_register_alu_execute_tb.sv
